>>> design/ual_pkg.sv
// ----------------------------------------------------------------------------
// Unordered array list package
// Request and response types and command codes shared by the list block.
// ----------------------------------------------------------------------------
package ual_pkg;

    localparam int CMD_W         = 2;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 5;
    localparam int ENTRY_COUNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_req;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] read_value;
        logic                      is_empty;
        logic                      is_full;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
    } t_rsp;

endpackage

>>> design/ual_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ual_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/unordered_array_list.sv
// ----------------------------------------------------------------------------
// Unordered array list
// Fixed-capacity list of 32-bit values with append, remove by value with
// shift-down, and read by position.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its single
// response appears on o_rsp for one cycle with o_valid, in the cycle after
// the work ends; the receiver must take it then. An insert does not raise
// busy, and a new request may follow at once. A read passes through S_READ.
// A remove walks the entry memory through its single read port, one entry
// per cycle: S_SRCH reads the entries in turn until one matches the value,
// then S_SHIFT reads each later entry and writes it one place down, and the
// count drops by one. A remove that finds nothing searches every entry and
// answers with ok low. A failed insert, a failed read, a remove on an empty
// list and an unused command answer straight from idle, with busy kept low.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module unordered_array_list #(
    parameter int CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ual_pkg::t_req i_req,
    output logic          o_valid,
    output ual_pkg::t_rsp o_rsp
);

    import ual_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SRCH,
        S_SHIFT
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic               r_valid, n_valid;
    t_rsp               r_rsp, n_rsp;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic [CMPW-1:0]    cap_ext;

    function automatic t_rsp make_rsp(input logic ok, input logic [VALUE_W-1:0] rd,
                                      input logic [CW-1:0] cnt);
        t_rsp rsp;
        rsp.ok          = ok;
        rsp.read_value  = rd;
        rsp.is_empty    = (cnt == '0);
        rsp.is_full     = (cnt == CAP);
        rsp.entry_count = ENTRY_COUNT_W'(cnt);
        return rsp;
    endfunction

    ual_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign pos_ext = CMPW'(i_req.position);
    assign cnt_ext = CMPW'(r_count);
    assign cap_ext = CMPW'(CAP);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_value   = r_value;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_req.cmd)
                        CMD_INSERT: begin
                            n_valid = 1'b1;
                            if (r_count < CAP) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_req.value;
                                n_count   = r_count + CW'(1);
                                n_rsp     = make_rsp(1'b1, '0, r_count + CW'(1));
                            end else begin
                                n_rsp = make_rsp(1'b0, '0, r_count);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                                n_rsp   = make_rsp(1'b0, '0, r_count);
                            end else begin
                                n_state = S_SRCH;
                                n_value = i_req.value;
                                n_idx   = '0;
                                n_pend  = 1'b0;
                            end
                        end
                        CMD_READ: begin
                            if (pos_ext < cnt_ext && pos_ext < cap_ext) begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_ext[AW-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_valid = 1'b1;
                                n_rsp   = make_rsp(1'b0, '0, r_count);
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_rsp   = make_rsp(1'b0, '0, r_count);
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_rsp   = make_rsp(1'b1, ram_rdata, r_count);
                n_state = S_IDLE;
            end
            S_SRCH: begin
                if (r_pend && ram_rdata == r_value) begin
                    n_state = S_SHIFT;
                    n_idx   = CW'(r_pidx) + CW'(1);
                    n_pend  = 1'b0;
                end else if (r_idx < r_count) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_rsp   = make_rsp(1'b0, '0, r_count);
                end
            end
            S_SHIFT: begin
                // The entry read last cycle moves down one place.
                ram_we = r_pend;
                if (r_idx < r_count) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = AW'(r_idx - CW'(1));
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                    n_count = r_count - CW'(1);
                    n_valid = 1'b1;
                    n_rsp   = make_rsp(1'b1, '0, r_count - CW'(1));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
            r_value <= n_value;
            r_idx   <= n_idx;
            r_pidx  <= n_pidx;
            r_rsp   <= n_rsp;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTH
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count exceeds capacity");

    a_rsp_has_req : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("response without a request in progress");

    a_no_write_in_search : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> !ram_we)
        else $error("entry memory written during search");

    a_read_value_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.read_value != '0) |-> o_rsp.ok)
        else $error("read value given on a failed request");
`endif

endmodule
